FILE: hdl/lltw_pkg.sv
// shared types, command and status codes for the lease lock table
package lltw_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int WAIT_DEPTH_DEF = 4;

    localparam logic [2:0] CMD_REQUEST = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_REMOTE  = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_CLR_ALL = 3'd4;
    localparam logic [2:0] CMD_CLR_USR = 3'd5;
    localparam logic [2:0] CMD_QUERY   = 3'd6;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_QUEUED  = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;
    localparam logic [1:0] STAT_NO_ROOM = 2'd3;

    localparam logic [1:0] NSTATE_UNLOCKED = 2'd0;
    localparam logic [1:0] NSTATE_LOCKED   = 2'd1;
    localparam logic [1:0] NSTATE_PENDING  = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] node_id;
        logic [15:0] user_id;
        logic [15:0] duration;
        logic [31:0] expiry_at;
        logic [15:0] elapsed;
    } t_cmd_in;

    typedef struct packed {
        logic        kind;
        logic [31:0] node_out;
        logic [15:0] user_out;
        logic        event_locked;
        logic [1:0]  status;
        logic        is_locked;
        logic        is_locked_by_user;
        logic        may_modify;
        logic [1:0]  node_state;
        logic [31:0] time_left;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] node;
        logic [15:0] owner;
        logic [31:0] expiry;
    } t_slot_rec;

    typedef struct packed {
        logic [15:0] user;
        logic [31:0] expiry;
    } t_wait_rec;

endpackage

FILE: hdl/lltw_ram.sv
// simple dual-port memory, one write port, one registered read port
module lltw_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: hdl/lease_lock_table_with_waiters.sv
// lease lock table top: command sequencer over the slot and waiter memories
//
//  channel   | handshake            | word
//  ----------+----------------------+--------------------------
//  command   | start, busy          | i_cmd   (t_cmd_in)
//  result    | o_strobe (no stall)  | o_result (t_result)
//
// lookups scan the slot memory one slot at a time, reading then checking each; a stale
// lease adds a grant step, and a release that promotes a waiter shifts its queue up
// tick and clear user walk every slot and the waiter queues entry by entry, a read
// then an act per step on the single-read-port memories
// reset clears time, slot flags and queue counts at once, no clearing pass
// results come one a cycle at most, the response with last set comes last
module lease_lock_table_with_waiters #(
    parameter int SLOTS      = lltw_pkg::SLOTS_DEF,
    parameter int WAIT_DEPTH = lltw_pkg::WAIT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lltw_pkg::t_cmd_in i_cmd,
    output logic              o_strobe,
    output lltw_pkg::t_result o_result
);
    import lltw_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WN  = SLOTS * WAIT_DEPTH;
    localparam int WA  = (WN > 1) ? $clog2(WN) : 1;
    localparam int KW  = $clog2(WAIT_DEPTH + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [KW-1:0] FULL_CNT  = KW'(WAIT_DEPTH);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SRD   = 5'd1;
    localparam logic [4:0] ST_SCHK  = 5'd2;
    localparam logic [4:0] ST_ACT   = 5'd3;
    localparam logic [4:0] ST_GNT   = 5'd4;
    localparam logic [4:0] ST_RESP  = 5'd5;
    localparam logic [4:0] ST_PRM0  = 5'd6;
    localparam logic [4:0] ST_PRMH  = 5'd7;
    localparam logic [4:0] ST_PRD   = 5'd8;
    localparam logic [4:0] ST_PWR   = 5'd9;
    localparam logic [4:0] ST_TRD   = 5'd10;
    localparam logic [4:0] ST_TCHK  = 5'd11;
    localparam logic [4:0] ST_TNEXT = 5'd12;
    localparam logic [4:0] ST_CRD   = 5'd13;
    localparam logic [4:0] ST_CCHK  = 5'd14;
    localparam logic [4:0] ST_URD   = 5'd15;
    localparam logic [4:0] ST_UCHK  = 5'd16;
    localparam logic [4:0] ST_UNEXT = 5'd17;
    localparam logic [4:0] ST_V0    = 5'd18;
    localparam logic [4:0] ST_VRD   = 5'd19;
    localparam logic [4:0] ST_VCHK  = 5'd20;
    localparam logic [4:0] ST_VNEXT = 5'd21;

    localparam logic [1:0] RET_RESP = 2'd0;
    localparam logic [1:0] RET_TICK = 2'd1;
    localparam logic [1:0] RET_USR  = 2'd2;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_result mk_event(input logic [31:0] node, input logic [15:0] user,
                                         input logic locked);
        t_result r;
        r              = '0;
        r.kind         = 1'b1;
        r.node_out     = node;
        r.user_out     = user;
        r.event_locked = locked;
        return r;
    endfunction

    function automatic logic [WA-1:0] waddr(input logic [SW-1:0] s, input logic [KW-1:0] k);
        return WA'(WA'(s) * WA'(WAIT_DEPTH) + WA'(k));
    endfunction

    logic [4:0]    r_state,  n_state;
    logic [1:0]    r_ret,    n_ret;
    logic          r_tidy,   n_tidy;
    t_cmd_in       r_in,     n_in;
    logic [31:0]   r_now,    n_now;
    logic          r_used [SLOTS];
    logic          n_used [SLOTS];
    logic          r_held [SLOTS];
    logic          n_held [SLOTS];
    logic [KW-1:0] r_wcnt [SLOTS];
    logic [KW-1:0] n_wcnt [SLOTS];
    logic [SW-1:0] r_s,      n_s;
    logic [KW-1:0] r_k,      n_k;
    logic [KW-1:0] r_n,      n_n;
    logic          r_found,  n_found;
    logic [SW-1:0] r_fslot,  n_fslot;
    logic          r_freeok, n_freeok;
    logic [SW-1:0] r_free,   n_free;
    t_slot_rec     r_rec,    n_rec;

    logic [1:0]    r_status, n_status;
    logic          r_qlock,  n_qlock;
    logic          r_quser,  n_quser;
    logic [1:0]    r_qstate, n_qstate;
    logic [31:0]   r_qleft,  n_qleft;
    logic [15:0]   r_uout,   n_uout;

    logic          r_ostb,   n_ostb;
    t_result       r_out,    n_out;

    logic          r_sw_en,   n_sw_en;
    logic [SW-1:0] r_sw_addr, n_sw_addr;
    t_slot_rec     r_sw_data, n_sw_data;
    logic          r_ww_en,   n_ww_en;
    logic [WA-1:0] r_ww_addr, n_ww_addr;
    t_wait_rec     r_ww_data, n_ww_data;

    t_slot_rec     w_sq;
    t_wait_rec     w_wq;
    logic [31:0]   w_sat;
    logic          w_rec_exp;
    logic [SW-1:0] w_tgt;

    lltw_ram #(.DW($bits(t_slot_rec)), .DEPTH(SLOTS), .AW(SW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (r_sw_en),
        .i_waddr (r_sw_addr),
        .i_wdata (r_sw_data),
        .i_raddr (r_s),
        .o_rdata (w_sq)
    );

    lltw_ram #(.DW($bits(t_wait_rec)), .DEPTH(WN), .AW(WA)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (r_ww_en),
        .i_waddr (r_ww_addr),
        .i_wdata (r_ww_data),
        .i_raddr (waddr(r_s, r_k)),
        .o_rdata (w_wq)
    );

    assign w_sat     = sat_add(r_now, r_in.duration);
    assign w_rec_exp = r_now > r_rec.expiry;
    assign w_tgt     = r_found ? r_fslot : r_free;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_tidy    = r_tidy;
        n_in      = r_in;
        n_now     = r_now;
        n_used    = r_used;
        n_held    = r_held;
        n_wcnt    = r_wcnt;
        n_s       = r_s;
        n_k       = r_k;
        n_n       = r_n;
        n_found   = r_found;
        n_fslot   = r_fslot;
        n_freeok  = r_freeok;
        n_free    = r_free;
        n_rec     = r_rec;
        n_status  = r_status;
        n_qlock   = r_qlock;
        n_quser   = r_quser;
        n_qstate  = r_qstate;
        n_qleft   = r_qleft;
        n_uout    = r_uout;
        n_ostb    = 1'b0;
        n_out     = r_out;
        n_sw_en   = 1'b0;
        n_sw_addr = r_sw_addr;
        n_sw_data = r_sw_data;
        n_ww_en   = 1'b0;
        n_ww_addr = r_ww_addr;
        n_ww_data = r_ww_data;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_in     = i_cmd;
                    n_s      = '0;
                    n_k      = '0;
                    n_found  = 1'b0;
                    n_freeok = 1'b0;
                    n_status = STAT_DONE;
                    n_qlock  = 1'b0;
                    n_quser  = 1'b0;
                    n_qstate = NSTATE_UNLOCKED;
                    n_qleft  = '0;
                    n_uout   = '0;
                    case (i_cmd.cmd)
                        CMD_REQUEST, CMD_RELEASE, CMD_REMOTE, CMD_QUERY: n_state = ST_SRD;
                        CMD_TICK: begin
                            n_now   = sat_add(r_now, i_cmd.elapsed);
                            n_state = ST_TRD;
                        end
                        CMD_CLR_ALL: n_state = ST_CRD;
                        CMD_CLR_USR: begin
                            if (i_cmd.user_id == '0) begin
                                n_status = STAT_REFUSED;
                                n_state  = ST_RESP;
                            end else begin
                                n_state = ST_URD;
                            end
                        end
                        default: begin
                            n_status = STAT_REFUSED;
                            n_state  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SRD: n_state = ST_SCHK;
            ST_SCHK: begin
                if (r_used[r_s] && w_sq.node == r_in.node_id && !r_found) begin
                    n_found = 1'b1;
                    n_fslot = r_s;
                    n_rec   = w_sq;
                end
                if (!r_used[r_s] && !r_freeok) begin
                    n_freeok = 1'b1;
                    n_free   = r_s;
                end
                if (r_s == LAST_SLOT) begin
                    n_state = ST_ACT;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ST_SRD;
                end
            end
            ST_ACT: begin
                n_state = ST_RESP;
                case (r_in.cmd)
                    CMD_REQUEST, CMD_REMOTE: begin
                        if (r_in.node_id == '0 || r_in.user_id == '0) begin
                            n_status = STAT_REFUSED;
                        end else if (r_found && r_held[r_fslot] &&
                                     (r_in.cmd == CMD_REQUEST || !w_rec_exp)) begin
                            if (r_in.cmd == CMD_REQUEST && w_rec_exp) begin
                                // stale lease: unlock event, then grant the requester
                                n_ostb    = 1'b1;
                                n_out     = mk_event(r_in.node_id, r_rec.owner, 1'b0);
                                n_sw_en   = 1'b1;
                                n_sw_addr = r_fslot;
                                n_sw_data = '{r_in.node_id, r_in.user_id, w_sat};
                                n_state   = ST_GNT;
                            end else if (r_rec.owner == r_in.user_id) begin
                                if (r_in.cmd == CMD_REQUEST) begin
                                    n_ostb    = 1'b1;
                                    n_out     = mk_event(r_in.node_id, r_in.user_id, 1'b1);
                                    n_sw_en   = 1'b1;
                                    n_sw_addr = r_fslot;
                                    n_sw_data = '{r_rec.node, r_rec.owner, w_sat};
                                end
                            end else if (r_wcnt[r_fslot] == FULL_CNT) begin
                                n_status = STAT_NO_ROOM;
                            end else begin
                                n_ww_en   = 1'b1;
                                n_ww_addr = waddr(r_fslot, r_wcnt[r_fslot]);
                                n_ww_data = '{r_in.user_id,
                                    (r_in.cmd == CMD_REQUEST) ? w_sat : r_in.expiry_at};
                                n_wcnt[r_fslot] = r_wcnt[r_fslot] + 1'b1;
                                n_status = STAT_QUEUED;
                            end
                        end else if (!r_found && !r_freeok) begin
                            n_status = STAT_NO_ROOM;
                        end else begin
                            n_used[w_tgt] = 1'b1;
                            n_held[w_tgt] = 1'b1;
                            if (!r_found) begin
                                n_wcnt[w_tgt] = '0;
                            end
                            n_sw_en   = 1'b1;
                            n_sw_addr = w_tgt;
                            n_sw_data = '{r_in.node_id, r_in.user_id,
                                (r_in.cmd == CMD_REQUEST) ? w_sat : r_in.expiry_at};
                            n_ostb    = 1'b1;
                            n_out     = mk_event(r_in.node_id, r_in.user_id, 1'b1);
                        end
                    end
                    CMD_RELEASE: begin
                        if (r_in.user_id == '0 || !r_found || !r_held[r_fslot] ||
                            r_rec.owner != r_in.user_id) begin
                            n_status = STAT_REFUSED;
                        end else begin
                            n_ostb          = 1'b1;
                            n_out           = mk_event(r_in.node_id, r_rec.owner, 1'b0);
                            n_held[r_fslot] = 1'b0;
                            n_s             = r_fslot;
                            n_k             = '0;
                            n_ret           = RET_RESP;
                            n_tidy          = 1'b1;
                            n_state         = ST_PRM0;
                        end
                    end
                    CMD_QUERY: begin
                        if (r_found) begin
                            if (r_held[r_fslot]) begin
                                if (!w_rec_exp) begin
                                    n_qlock  = 1'b1;
                                    n_qstate = NSTATE_LOCKED;
                                    n_uout   = r_rec.owner;
                                    n_qleft  = r_rec.expiry - r_now;
                                    n_quser  = r_rec.owner == r_in.user_id;
                                end
                            end else if (r_wcnt[r_fslot] != '0) begin
                                n_qstate = NSTATE_PENDING;
                            end
                        end
                    end
                    default: n_status = STAT_REFUSED;
                endcase
            end
            ST_GNT: begin
                n_ostb  = 1'b1;
                n_out   = mk_event(r_in.node_id, r_in.user_id, 1'b1);
                n_state = ST_RESP;
            end
            // promote head waiter of slot r_s, then return
            ST_PRM0: begin
                if (r_wcnt[r_s] == '0) begin
                    if (r_tidy) begin
                        n_used[r_s] = 1'b0;
                    end
                    n_state = (r_ret == RET_RESP) ? ST_RESP :
                              (r_ret == RET_TICK) ? ST_TNEXT : ST_UNEXT;
                end else begin
                    n_state = ST_PRMH;
                end
            end
            ST_PRMH: begin
                n_sw_en     = 1'b1;
                n_sw_addr   = r_s;
                n_sw_data   = '{r_rec.node, w_wq.user, w_wq.expiry};
                n_held[r_s] = 1'b1;
                n_ostb      = 1'b1;
                n_out       = mk_event(r_rec.node, w_wq.user, 1'b1);
                n_k         = KW'(1);
                if (r_wcnt[r_s] == KW'(1)) begin
                    n_wcnt[r_s] = '0;
                    n_state = (r_ret == RET_RESP) ? ST_RESP :
                              (r_ret == RET_TICK) ? ST_TNEXT : ST_UNEXT;
                end else begin
                    n_state = ST_PRD;
                end
            end
            ST_PRD: n_state = ST_PWR;
            ST_PWR: begin
                n_ww_en   = 1'b1;
                n_ww_addr = waddr(r_s, r_k - 1'b1);
                n_ww_data = w_wq;
                if (r_k == r_wcnt[r_s] - 1'b1) begin
                    n_wcnt[r_s] = r_wcnt[r_s] - 1'b1;
                    n_state = (r_ret == RET_RESP) ? ST_RESP :
                              (r_ret == RET_TICK) ? ST_TNEXT : ST_UNEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_PRD;
                end
            end
            ST_TRD: n_state = ST_TCHK;
            ST_TCHK: begin
                if (r_used[r_s] && r_held[r_s] && r_now > w_sq.expiry) begin
                    n_rec       = w_sq;
                    n_ostb      = 1'b1;
                    n_out       = mk_event(w_sq.node, w_sq.owner, 1'b0);
                    n_held[r_s] = 1'b0;
                    n_k         = '0;
                    n_ret       = RET_TICK;
                    n_tidy      = 1'b1;
                    n_state     = ST_PRM0;
                end else begin
                    n_state = ST_TNEXT;
                end
            end
            ST_TNEXT: begin
                if (r_s == LAST_SLOT) begin
                    n_state = ST_RESP;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_k     = '0;
                    n_state = ST_TRD;
                end
            end
            ST_CRD: n_state = ST_CCHK;
            ST_CCHK: begin
                if (r_used[r_s] && r_held[r_s]) begin
                    n_ostb = 1'b1;
                    n_out  = mk_event(w_sq.node, 16'd0, 1'b0);
                end
                if (r_s == LAST_SLOT) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        n_used[i] = 1'b0;
                        n_held[i] = 1'b0;
                        n_wcnt[i] = '0;
                    end
                    n_state = ST_RESP;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ST_CRD;
                end
            end
            ST_URD: n_state = ST_UCHK;
            ST_UCHK: begin
                if (r_used[r_s] && r_held[r_s] && w_sq.owner == r_in.user_id) begin
                    n_rec       = w_sq;
                    n_ostb      = 1'b1;
                    n_out       = mk_event(w_sq.node, w_sq.owner, 1'b0);
                    n_held[r_s] = 1'b0;
                    n_k         = '0;
                    n_ret       = RET_USR;
                    n_tidy      = 1'b0;
                    n_state     = ST_PRM0;
                end else begin
                    n_state = ST_UNEXT;
                end
            end
            ST_UNEXT: begin
                n_k = '0;
                if (r_s == LAST_SLOT) begin
                    n_s     = '0;
                    n_state = ST_V0;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ST_URD;
                end
            end
            // purge the user's waits, compacting in place
            ST_V0: begin
                n_k     = '0;
                n_n     = '0;
                n_state = r_used[r_s] ? ST_VRD : ST_VNEXT;
            end
            ST_VRD: begin
                if (r_k == r_wcnt[r_s]) begin
                    n_wcnt[r_s] = r_n;
                    if (!r_held[r_s] && r_n == '0) begin
                        n_used[r_s] = 1'b0;
                    end
                    n_state = ST_VNEXT;
                end else begin
                    n_state = ST_VCHK;
                end
            end
            ST_VCHK: begin
                if (w_wq.user != r_in.user_id) begin
                    n_ww_en   = 1'b1;
                    n_ww_addr = waddr(r_s, r_n);
                    n_ww_data = w_wq;
                    n_n       = r_n + 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = ST_VRD;
            end
            ST_VNEXT: begin
                if (r_s == LAST_SLOT) begin
                    n_state = ST_RESP;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ST_V0;
                end
            end
            ST_RESP: begin
                n_ostb                  = 1'b1;
                n_out                   = '0;
                n_out.node_out          = (r_in.cmd inside {CMD_TICK, CMD_CLR_ALL,
                                          CMD_CLR_USR}) ? 32'd0 : r_in.node_id;
                n_out.user_out          = r_uout;
                n_out.status            = r_status;
                n_out.is_locked         = r_qlock;
                n_out.is_locked_by_user = r_quser;
                n_out.may_modify        = (r_in.cmd == CMD_QUERY) &&
                                          (!r_qlock || r_quser);
                n_out.node_state        = r_qstate;
                n_out.time_left         = r_qleft;
                n_out.last              = 1'b1;
                n_state                 = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_now   <= '0;
            r_ostb  <= 1'b0;
            r_sw_en <= 1'b0;
            r_ww_en <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_used[i] <= 1'b0;
                r_held[i] <= 1'b0;
                r_wcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_ostb  <= n_ostb;
            r_sw_en <= n_sw_en;
            r_ww_en <= n_ww_en;
            r_used  <= n_used;
            r_held  <= n_held;
            r_wcnt  <= n_wcnt;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_ret     <= n_ret;
        r_tidy    <= n_tidy;
        r_in      <= n_in;
        r_s       <= n_s;
        r_k       <= n_k;
        r_n       <= n_n;
        r_found   <= n_found;
        r_fslot   <= n_fslot;
        r_freeok  <= n_freeok;
        r_free    <= n_free;
        r_rec     <= n_rec;
        r_status  <= n_status;
        r_qlock   <= n_qlock;
        r_quser   <= n_quser;
        r_qstate  <= n_qstate;
        r_qleft   <= n_qleft;
        r_uout    <= n_uout;
        r_out     <= n_out;
        r_sw_addr <= n_sw_addr;
        r_sw_data <= n_sw_data;
        r_ww_addr <= n_ww_addr;
        r_ww_data <= n_ww_data;
    end

    assign busy     = r_state != ST_IDLE;
    assign o_strobe = r_ostb;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("final word while still busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start a sequence");
    a_event_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind |-> o_result.status == STAT_DONE && !o_result.last)
        else $error("event word carries status or last");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_ww_en || $past(r_state) != ST_IDLE)
        else $error("waiter write while idle");
`endif
endmodule
